FILE: hw/rtl/cassette_tape_deck_controller_unit_assert.svh
// Assertion macros shared by the cassette deck checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CASSETTE_TAPE_DECK_CONTROLLER_UNIT_ASSERT_SVH
`define CASSETTE_TAPE_DECK_CONTROLLER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ctdc_pkg.sv
// Shared types and constants for the cassette tape deck controller.
// Used by the top level and by the port checker; depends on nothing.
package ctdc_pkg;

    localparam int RATE_W    = 27;
    localparam int POS_W     = 20;
    localparam int FREQ_W    = 16;
    localparam int SENS_W    = 3;
    localparam int CMD_W     = 8;
    localparam int PORT_W    = 2;
    localparam int DIV_CNT_W = 5;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RATE_W - 1);

    // Whole ticks per millisecond: (rate >> 3) * ceil(2^30 / 125) >> 30.
    // This is exact for every rate below 2^27.
    localparam int MS_IN_W   = RATE_W - 3;
    localparam int MS_PROD_W = 2 * MS_IN_W;
    localparam int MS_SHIFT  = 30;
    localparam logic [MS_IN_W-1:0] MS_RECIP = 24'd8589935;

    // Item operation codes.
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_CMD    = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_INSERT = 3'd3;
    localparam logic [2:0] OP_LOAD   = 3'd4;

    // Deck command bytes.
    localparam logic [CMD_W-1:0] CMD_EJECT = 8'h00;
    localparam logic [CMD_W-1:0] CMD_STOP  = 8'h01;
    localparam logic [CMD_W-1:0] CMD_PLAY  = 8'h02;
    localparam logic [CMD_W-1:0] CMD_FF    = 8'h03;
    localparam logic [CMD_W-1:0] CMD_REW   = 8'h04;
    localparam logic [CMD_W-1:0] CMD_STAT0 = 8'h80;
    localparam logic [CMD_W-1:0] CMD_STAT1 = 8'h81;

    // Sensor bits.
    localparam logic [SENS_W-1:0] SENS_MOTOR = 3'b001;
    localparam logic [SENS_W-1:0] SENS_TAPE  = 3'b010;
    localparam logic [SENS_W-1:0] SENS_WREN  = 3'b100;

    // Data port answers.
    localparam logic [PORT_W-1:0] PORT_NONE = 2'd0;
    localparam logic [PORT_W-1:0] PORT_ONE  = 2'd2;

    localparam logic [FREQ_W-1:0] DEFAULT_FREQ = 16'd8000;
    localparam logic [FREQ_W-1:0] MS_DIVISOR   = 16'd1000;
    localparam logic [RATE_W-1:0] HALF_SEC_MS  = 27'd500;
    localparam logic [RATE_W-1:0] RATE_RESET   = 27'd4000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV_MS,
        ST_HALF,
        ST_DIV_BIT
    } ctdc_state_t;

endpackage

FILE: hw/rtl/cassette_tape_deck_controller_unit.sv
// Cassette tape deck controller: tape byte store, play timer and command decoder.
// Depends on ctdc_pkg for codes, widths and the sequencer state type.
//
// Usage:
// Items enter on the in_valid/in_ready channel: a clock tick, a control command,
// a data port read, a tape insert or a tape byte load. Every item gives exactly
// one result on out_valid/out_ready: port data, sensor bits, the current command
// and the motor-stopped flag. The clock rate register is written on the
// cfg_valid/cfg_ready channel, which is ready whenever the deck is idle.
// Ticks, commands, inserts and loads finish in the accepting cycle: the result is
// in the output register after the accepting edge, and the next item can enter
// in that cycle if the receiver takes the result. A data port read passes the
// registered read of the tape memory and the ST_READ state. A play command that
// starts the motor passes the accepting cycle, ST_DIV_MS for the reciprocal
// multiply that gives whole ticks per millisecond, ST_HALF for the half-second
// scaling multiply, and 27 restoring divider steps for the bit interval.
// Reset clears all deck state and sets the clock rate to 4000000; the tape
// memory is not cleared and holds garbage until loaded. When the receiver
// stalls, the result waits in the output register and no new item is taken
// until it leaves; a new item is taken in the cycle the old result is taken.
// TAPE_BYTES must be a power of two so that byte indexes wrap by truncation.
module cassette_tape_deck_controller_unit
    import ctdc_pkg::*;
#(
    parameter int TAPE_BYTES = 65536
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [RATE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           op,
    input  logic [CMD_W-1:0]     command,
    input  logic [15:0]          load_address,
    input  logic [7:0]           load_byte,
    input  logic [POS_W-1:0]     tape_bits,
    input  logic [FREQ_W-1:0]    tape_frequency,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PORT_W-1:0]    port_data,
    output logic [SENS_W-1:0]    sensor_status,
    output logic [CMD_W-1:0]     command_status,
    output logic                 motor_stopped
);

    localparam int ADDR_W = $clog2(TAPE_BYTES);

    logic [7:0] tape_mem [TAPE_BYTES];
    logic [7:0] mem_rdata_reg;

    ctdc_state_t state_reg, state_next;

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     len_reg, len_next;
    logic [FREQ_W-1:0]    freq_reg, freq_next;
    logic [SENS_W-1:0]    sensor_reg, sensor_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [RATE_W-1:0]    interval_reg, interval_next;
    logic [RATE_W-1:0]    countdown_reg, countdown_next;
    logic                 armed_reg, armed_next;
    logic [RATE_W-1:0]    rate_reg;

    logic [FREQ_W-1:0]    div_rem_reg, div_rem_next;
    logic [RATE_W-1:0]    div_quo_reg, div_quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic                 out_valid_reg, out_valid_next;
    logic [PORT_W-1:0]    port_reg, port_next;
    logic [SENS_W-1:0]    sens_out_reg, sens_out_next;
    logic [CMD_W-1:0]     cmd_out_reg, cmd_out_next;

    logic                 accept;
    logic                 finish;
    logic [PORT_W-1:0]    port_val;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;

    logic [MS_PROD_W-1:0] ms_prod;
    logic [FREQ_W-1:0]    div_divisor;
    logic [FREQ_W:0]      rem_shift;
    logic                 div_ge;
    logic [FREQ_W-1:0]    rem_step;
    logic [RATE_W-1:0]    quo_step;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;

    assign wr_addr = ADDR_W'(load_address);
    assign rd_addr = ADDR_W'(pos_reg[POS_W-1:3]);

    assign ms_prod = MS_PROD_W'(rate_reg[RATE_W-1:3]) * MS_PROD_W'(MS_RECIP);

    // One step of the restoring divider for the bit interval.
    assign div_divisor = freq_reg;
    assign rem_shift   = {div_rem_reg, div_quo_reg[RATE_W-1]};
    assign div_ge      = (rem_shift >= {1'b0, div_divisor});
    assign rem_step    = div_ge ? FREQ_W'(rem_shift - {1'b0, div_divisor})
                                : rem_shift[FREQ_W-1:0];
    assign quo_step    = {div_quo_reg[RATE_W-2:0], div_ge};

    always_ff @(posedge clk)
    begin
        if (accept && op == OP_LOAD)
        begin
            tape_mem[wr_addr] <= load_byte;
        end
        if (accept && op == OP_READ)
        begin
            mem_rdata_reg <= tape_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            len_reg       <= '0;
            freq_reg      <= '0;
            sensor_reg    <= '0;
            cmd_reg       <= CMD_STOP;
            interval_reg  <= '0;
            countdown_reg <= '0;
            armed_reg     <= 1'b0;
            rate_reg      <= RATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            freq_reg      <= freq_next;
            sensor_reg    <= sensor_next;
            cmd_reg       <= cmd_next;
            interval_reg  <= interval_next;
            countdown_reg <= countdown_next;
            armed_reg     <= armed_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                rate_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_cnt_reg  <= div_cnt_next;
        port_reg     <= port_next;
        sens_out_reg <= sens_out_next;
        cmd_out_reg  <= cmd_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        freq_next      = freq_reg;
        sensor_next    = sensor_reg;
        cmd_next       = cmd_reg;
        interval_next  = interval_reg;
        countdown_next = countdown_reg;
        armed_next     = armed_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_cnt_next   = div_cnt_reg;
        port_next      = port_reg;
        sens_out_next  = sens_out_reg;
        cmd_out_next   = cmd_out_reg;
        finish         = 1'b0;
        port_val       = PORT_NONE;

        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    finish = 1'b1;
                    unique case (op)
                        OP_TICK:
                        begin
                            if (armed_reg)
                            begin
                                if (countdown_reg <= RATE_W'(1))
                                begin
                                    // Timer fires: advance one bit or stop at the end.
                                    if (len_reg != '0 && pos_reg < len_reg - POS_W'(1))
                                    begin
                                        pos_next       = pos_reg + POS_W'(1);
                                        sensor_next    = sensor_reg | SENS_MOTOR;
                                        countdown_next = interval_reg;
                                        armed_next     = 1'b1;
                                    end
                                    else
                                    begin
                                        cmd_next       = CMD_STOP;
                                        armed_next     = 1'b0;
                                        countdown_next = '0;
                                        sensor_next    = sensor_reg & ~SENS_MOTOR;
                                    end
                                end
                                else
                                begin
                                    countdown_next = countdown_reg - RATE_W'(1);
                                end
                            end
                        end
                        OP_CMD:
                        begin
                            priority if (command == CMD_STAT0 || command == CMD_STAT1)
                            begin
                                cmd_next = cmd_reg;
                            end
                            else if (freq_reg == '0 && command != CMD_EJECT
                                     && command != CMD_STOP)
                            begin
                                cmd_next = CMD_STOP;
                            end
                            else
                            begin
                                cmd_next = command;
                                unique case (command)
                                    CMD_EJECT:
                                    begin
                                        armed_next     = 1'b0;
                                        countdown_next = '0;
                                        sensor_next    = '0;
                                        freq_next      = '0;
                                    end
                                    CMD_STOP:
                                    begin
                                        armed_next     = 1'b0;
                                        countdown_next = '0;
                                        sensor_next    = sensor_reg & ~SENS_MOTOR;
                                    end
                                    CMD_PLAY:
                                    begin
                                        // With a tape present, work out the half-second
                                        // delay and the bit interval before answering.
                                        if ((sensor_reg & SENS_TAPE) != '0)
                                        begin
                                            finish     = 1'b0;
                                            state_next = ST_DIV_MS;
                                        end
                                    end
                                    CMD_FF:
                                    begin
                                        if (len_reg != '0)
                                        begin
                                            pos_next = len_reg;
                                        end
                                        cmd_next       = CMD_STOP;
                                        armed_next     = 1'b0;
                                        countdown_next = '0;
                                        sensor_next    = sensor_reg & ~SENS_MOTOR;
                                    end
                                    CMD_REW:
                                    begin
                                        pos_next       = '0;
                                        cmd_next       = CMD_STOP;
                                        armed_next     = 1'b0;
                                        countdown_next = '0;
                                        sensor_next    = sensor_reg & ~SENS_MOTOR;
                                    end
                                    default:
                                    begin
                                        cmd_next = command;
                                    end
                                endcase
                            end
                        end
                        OP_READ:
                        begin
                            finish     = 1'b0;
                            state_next = ST_READ;
                        end
                        OP_INSERT:
                        begin
                            cmd_next       = CMD_STOP;
                            armed_next     = 1'b0;
                            countdown_next = '0;
                            len_next       = tape_bits;
                            freq_next      = (tape_frequency != '0) ? tape_frequency
                                                                    : DEFAULT_FREQ;
                            pos_next       = '0;
                            sensor_next    = SENS_TAPE | SENS_WREN;
                        end
                        default:
                        begin
                            // Loads go straight to the memory; unknown ops only report.
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                finish     = 1'b1;
                state_next = ST_IDLE;
                if (cmd_reg == CMD_PLAY && freq_reg != '0 && mem_rdata_reg[~pos_reg[2:0]])
                begin
                    port_val = PORT_ONE;
                end
            end
            ST_DIV_MS:
            begin
                // The rate over eight, divided by 125 through its reciprocal.
                div_quo_next = RATE_W'(ms_prod[MS_PROD_W-1:MS_SHIFT]);
                state_next   = ST_HALF;
            end
            ST_HALF:
            begin
                // Ticks per millisecond times 500 gives the half-second delay.
                countdown_next = div_quo_reg * HALF_SEC_MS;
                div_quo_next   = rate_reg;
                div_rem_next   = '0;
                div_cnt_next   = DIV_LAST;
                state_next     = ST_DIV_BIT;
            end
            ST_DIV_BIT:
            begin
                div_rem_next = rem_step;
                div_quo_next = quo_step;
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == '0)
                begin
                    interval_next = quo_step;
                    sensor_next   = sensor_reg | SENS_MOTOR;
                    armed_next    = 1'b1;
                    finish        = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            out_valid_next = 1'b1;
            port_next      = port_val;
            sens_out_next  = sensor_next;
            cmd_out_next   = cmd_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign port_data      = port_reg;
    assign sensor_status  = sens_out_reg;
    assign command_status = cmd_out_reg;
    assign motor_stopped  = ~sens_out_reg[0];

endmodule

FILE: hw/rtl/ctdc_checker.sv
// Port checker for the cassette tape deck controller, bound to the top level.
// Depends on ctdc_pkg and on the assertion macros in the shared header.
`include "cassette_tape_deck_controller_unit_assert.svh"

module ctdc_checker
    import ctdc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [PORT_W-1:0] port_data,
    input logic [SENS_W-1:0] sensor_status,
    input logic [CMD_W-1:0]  command_status,
    input logic              motor_stopped
);

    `CTDC_ASSERT_NOW(a_motor_flag, out_valid, motor_stopped == !sensor_status[0], "motor flag disagrees with sensor bits")

    `CTDC_ASSERT_NOW(a_port_code, out_valid, port_data == PORT_NONE || port_data == PORT_ONE, "port data outside its codes")

    // A one bit is only read back while the deck plays a tape.
    `CTDC_ASSERT_NOW(a_port_play, out_valid && port_data == PORT_ONE, command_status == CMD_PLAY && sensor_status[1], "tape bit reported while not playing")

    // The motor can only run with a tape in the deck.
    `CTDC_ASSERT_NOW(a_motor_tape, out_valid && sensor_status[0], sensor_status[1], "motor running without a tape")

    `CTDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(command_status) && $stable(sensor_status), "stalled result changed")

endmodule

bind cassette_tape_deck_controller_unit ctdc_checker u_ctdc_checker (.*);
